>>> hdl/dmic_pkg.sv
package dmic_pkg;

   localparam int NUM_LINES   = 256;
   localparam int LINE_BYTES  = 16;
   localparam int CACHE_BYTES = NUM_LINES * LINE_BYTES;
   localparam int WORD_BYTES  = 4;
   localparam int NUM_WORDS   = CACHE_BYTES / WORD_BYTES;

   localparam int ADDR_W      = 32;
   localparam int DATA_W      = 32;
   localparam int OFF_W       = $clog2(LINE_BYTES);
   localparam int IDX_W       = $clog2(NUM_LINES);
   localparam int BADDR_W     = $clog2(CACHE_BYTES);
   localparam int WADDR_W     = $clog2(NUM_WORDS);
   localparam int BSEL_W      = $clog2(WORD_BYTES);
   localparam int TAG_W       = ADDR_W - BADDR_W;
   localparam int OP_W        = 3;
   localparam int CSR_ADDR_W  = 3;

   // csr byte addresses
   localparam logic [CSR_ADDR_W-1:0] CSR_ISOLATED = 3'h0;

   typedef enum logic [OP_W-1:0] {
      OP_HIT_CHECK  = 3'd0,
      OP_READ_WORD  = 3'd1,
      OP_READ_BYTE  = 3'd2,
      OP_WRITE_WORD = 3'd3,
      OP_WRITE_BYTE = 3'd4,
      OP_REFILL     = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic exec;
      logic resp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

>>> hdl/dmic_ctrl.sv
module dmic_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  dmic_pkg::status_type status,
   output dmic_pkg::cmd_type    cmd,
   output logic                 busy
);

   dmic_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmic_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmic_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = dmic_pkg::ST_IDLE;
         end
         dmic_pkg::ST_IDLE: begin
            if (start) state_in = dmic_pkg::ST_EXEC;
         end
         dmic_pkg::ST_EXEC: begin
            state_in = dmic_pkg::ST_RESP;
         end
         dmic_pkg::ST_RESP: begin
            state_in = dmic_pkg::ST_IDLE;
         end
         default: begin
            state_in = dmic_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         dmic_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         dmic_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         dmic_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         dmic_pkg::ST_RESP: begin
            cmd.resp = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> hdl/dmic_dpath.sv
module dmic_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  dmic_pkg::cmd_type                 cmd,
   output dmic_pkg::status_type              status,
   input  logic                              isolated,
   input  logic [dmic_pkg::OP_W-1:0]         req_operation,
   input  logic [dmic_pkg::ADDR_W-1:0]       req_phys_address,
   input  logic [dmic_pkg::DATA_W-1:0]       req_write_data,
   output logic                              rsp_strobe,
   output logic                              rsp_hit,
   output logic [dmic_pkg::DATA_W-1:0]       rsp_read_data
);

   // word-wide data store, lane 3 holds the lowest byte address (big-endian)
   logic [dmic_pkg::WORD_BYTES-1:0][7:0] data_mem [dmic_pkg::NUM_WORDS];
   logic [dmic_pkg::TAG_W-1:0]           tag_mem  [dmic_pkg::NUM_LINES];

   logic [dmic_pkg::NUM_LINES-1:0]       valid_ff, valid_in;
   logic [dmic_pkg::WADDR_W-1:0]         clr_addr_ff, clr_addr_in;

   logic [dmic_pkg::OP_W-1:0]            op_ff;
   logic [dmic_pkg::ADDR_W-1:0]          addr_ff;
   logic [dmic_pkg::DATA_W-1:0]          wdata_ff;

   logic [dmic_pkg::WORD_BYTES-1:0][7:0] rd_word_ff;
   logic [dmic_pkg::TAG_W-1:0]           rd_tag_ff;
   logic                                 rd_valid_ff;

   logic                                 strobe_ff;
   logic                                 hit_ff;
   logic [dmic_pkg::DATA_W-1:0]          rdata_ff;

   logic [dmic_pkg::WADDR_W-1:0]         word_addr;
   logic [dmic_pkg::BSEL_W-1:0]          byte_sel;
   logic [dmic_pkg::BSEL_W-1:0]          byte_lane;
   logic [dmic_pkg::IDX_W-1:0]           line_idx;
   logic [dmic_pkg::TAG_W-1:0]           line_tag;
   logic                                 is_write;
   logic                                 is_refill;
   logic                                 tag_we;

   logic [dmic_pkg::WADDR_W-1:0]         mem_addr;
   logic [dmic_pkg::WORD_BYTES-1:0]      mem_be;
   logic [dmic_pkg::WORD_BYTES-1:0][7:0] mem_wdata;

   assign word_addr = addr_ff[dmic_pkg::BADDR_W-1:dmic_pkg::BSEL_W];
   assign byte_sel  = addr_ff[dmic_pkg::BSEL_W-1:0];
   assign byte_lane = ~byte_sel;
   assign line_idx  = addr_ff[dmic_pkg::BADDR_W-1:dmic_pkg::OFF_W];
   assign line_tag  = addr_ff[dmic_pkg::ADDR_W-1:dmic_pkg::BADDR_W];

   assign is_write  = (op_ff == dmic_pkg::OP_WRITE_WORD) || (op_ff == dmic_pkg::OP_WRITE_BYTE);
   assign is_refill = (op_ff == dmic_pkg::OP_REFILL) && !isolated;
   assign tag_we    = cmd.exec && ((is_write && isolated) || is_refill);

   assign status.clear_last = (clr_addr_ff == {dmic_pkg::WADDR_W{1'b1}});

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         addr_ff  <= req_phys_address;
         wdata_ff <= req_write_data;
      end
   end

   // clearing pass counter
   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.clear) clr_addr_in = clr_addr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // data store port
   always_comb begin
      mem_addr  = word_addr;
      mem_be    = '0;
      mem_wdata = wdata_ff;
      if (cmd.clear) begin
         mem_addr  = clr_addr_ff;
         mem_be    = '1;
         mem_wdata = '0;
      end else if (cmd.exec) begin
         case (op_ff)
            dmic_pkg::OP_WRITE_WORD: begin
               mem_be = '1;
            end
            dmic_pkg::OP_WRITE_BYTE: begin
               mem_be[byte_lane] = 1'b1;
               mem_wdata         = {dmic_pkg::WORD_BYTES{wdata_ff[7:0]}};
            end
            dmic_pkg::OP_REFILL: begin
               mem_be = {dmic_pkg::WORD_BYTES{!isolated}};
            end
            default: begin
               mem_be = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < dmic_pkg::WORD_BYTES; i++) begin
         if (mem_be[i]) data_mem[mem_addr][i] <= mem_wdata[i];
      end
      if (cmd.exec) rd_word_ff <= data_mem[mem_addr];
   end

   // tag store, only looked at when the line is valid
   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[line_idx] <= line_tag;
      if (cmd.exec) rd_tag_ff <= tag_mem[line_idx];
   end

   // valid bits
   always_comb begin
      valid_in = valid_ff;
      if (cmd.exec) begin
         if (is_refill) valid_in[line_idx] = 1'b1;
         else if (is_write && isolated) valid_in[line_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) rd_valid_ff <= valid_ff[line_idx];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.resp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp) begin
         hit_ff <= (op_ff == dmic_pkg::OP_HIT_CHECK) && rd_valid_ff && (rd_tag_ff == line_tag);
         case (op_ff)
            dmic_pkg::OP_READ_WORD: rdata_ff <= rd_word_ff;
            dmic_pkg::OP_READ_BYTE: rdata_ff <= {24'h0, rd_word_ff[byte_lane]};
            default:                rdata_ff <= '0;
         endcase
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_read_data = rdata_ff;

endmodule

>>> hdl/direct_mapped_icache_store.sv
// channel   direction  handshake                     payload
// request   in         start & !busy                 req_operation, req_phys_address,
//                                                    req_write_data
// response  out        rsp_strobe, one cycle         rsp_hit, rsp_read_data
// csr       in/out     psel & penable & pwrite       pwdata[0] -> isolated
//
// a new item is taken only once the last one is through: capture, store access (registered read), result register;
// the strobe rises with the result register, and busy is low again in that cycle.
// after reset a clearing pass zeroes the 1024-word data store, one word per cycle,
// and busy stays high until the pass ends; valid bits clear at once.
// the receiver cannot stall: each result shows for exactly one cycle.
module direct_mapped_icache_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [dmic_pkg::OP_W-1:0]             req_operation,
   input  logic [dmic_pkg::ADDR_W-1:0]           req_phys_address,
   input  logic [dmic_pkg::DATA_W-1:0]           req_write_data,
   output logic                                  rsp_strobe,
   output logic                                  rsp_hit,
   output logic [dmic_pkg::DATA_W-1:0]           rsp_read_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [dmic_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   dmic_pkg::cmd_type    cmd;
   dmic_pkg::status_type status;
   logic                 isolated_ff;
   logic                 csr_sel;

   // register decode ignores the byte bits
   assign csr_sel = (paddr[dmic_pkg::CSR_ADDR_W-1:2] ==
                     dmic_pkg::CSR_ISOLATED[dmic_pkg::CSR_ADDR_W-1:2]);
   assign pready  = 1'b1;
   assign prdata  = csr_sel ? {31'h0, isolated_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         isolated_ff <= 1'b0;
      end else if (psel && penable && pwrite && csr_sel) begin
         isolated_ff <= pwdata[0];
      end
   end

   dmic_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   dmic_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .isolated         (isolated_ff),
      .req_operation    (req_operation),
      .req_phys_address (req_phys_address),
      .req_write_data   (req_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_read_data    (rsp_read_data)
   );

endmodule

>>> hdl/dmic_chk.sv
module dmic_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic                            rsp_hit,
   input logic [dmic_pkg::DATA_W-1:0]     rsp_read_data
);

   // accepted item goes busy and its result strobe follows
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##2 rsp_strobe)
      else $error("result missing three cycles after accept");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   a_hit_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> (rsp_read_data == '0))
      else $error("hit check returned read data");

endmodule

bind direct_mapped_icache_store dmic_chk u_dmic_chk (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_hit       (rsp_hit),
   .rsp_read_data (rsp_read_data)
);
